FILE: design/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, opcodes and controller/datapath interface for the register
// stack machine core.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int WORD_W        = 32;
  localparam int NUM_REGS      = 5;
  localparam int REG_IDX_W     = 3;
  localparam int PC_OUT_W      = 10;
  localparam int PROGRAM_WORDS = 1024;
  localparam int DATA_WORDS    = 1024;
  localparam int STACK_DEPTH   = 256;
  localparam int DIV_STEPS     = 32;
  localparam int DIV_CNT_W     = 5;

  // Step commands
  typedef enum logic [1:0] {
    CMD_EXEC   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SET_PC = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Opcodes, dense from zero
  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_NOT,
    OP_SHL, OP_SHR, OP_CMP, OP_JMP, OP_JEQ, OP_JNE, OP_JLT, OP_JGT, OP_JLE,
    OP_JGE, OP_PUSH, OP_POP, OP_LOAD, OP_STORE, OP_MOV, OP_MOVR, OP_PRINT,
    OP_READ, OP_NOP, OP_HALT
  } op_t;

  localparam logic [WORD_W-1:0] OP_LAST = WORD_W'(OP_HALT);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OPC, ST_ARG1, ST_ARG2, ST_EXEC, ST_MEM, ST_DIVS, ST_DIVW, ST_FIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic latch_op;
    logic fetch;
    logic latch_x;
    logic latch_y;
    logic exec;
    logic mem_wb;
    logic div_step;
    logic div_wb;
    logic publish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       in_is_exec;
    logic [1:0] new_args;
    logic [1:0] cur_args;
    logic       mem_rd;
    logic       div_run;
    logic       div_last;
    logic       out_free;
  } dp_status_t;

  // Number of operand words that follow an opcode
  function automatic logic [1:0] op_args(input op_t op);
    logic [1:0] n;
    n = 2'd0;
    unique case (op)
      OP_MOV, OP_MOVR: n = 2'd2;
      OP_PRINT:        n = 2'd1;
      default:         n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: design/rsm_ram.sv
// ----------------------------------------------------------------------------
// rsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsm_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rsm_ctrl.sv
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer: accept, fetch opcode and operands, execute, memory or divide
// wait, then hand the result to the output register.
// ----------------------------------------------------------------------------
module rsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsm_pkg::dp_status_t st,
  output rsm_pkg::ctrl_cmd_t  cmd
);

  import rsm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = st.in_is_exec ? ST_OPC : ST_FIN;
        end
      end
      ST_OPC: begin
        cmd.latch_op = 1'b1;
        if (st.new_args != 2'd0) begin
          cmd.fetch = 1'b1;
          state_nxt = ST_ARG1;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_ARG1: begin
        cmd.latch_x = 1'b1;
        if (st.cur_args == 2'd2) begin
          cmd.fetch = 1'b1;
          state_nxt = ST_ARG2;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_ARG2: begin
        cmd.latch_y = 1'b1;
        state_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (st.mem_rd) begin
          state_nxt = ST_MEM;
        end else if (st.div_run) begin
          state_nxt = ST_DIVS;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MEM: begin
        cmd.mem_wb = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        cmd.div_wb = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/rsm_datapath.sv
// ----------------------------------------------------------------------------
// rsm_datapath
// Register file, PC, stack pointer, ALU, serial divider, the program, stack
// and data RAMs, and the output register.
// ----------------------------------------------------------------------------
module rsm_datapath #(
  parameter int PROGRAM_WORDS = rsm_pkg::PROGRAM_WORDS,
  parameter int DATA_WORDS    = rsm_pkg::DATA_WORDS,
  parameter int STACK_DEPTH   = rsm_pkg::STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rsm_pkg::ctrl_cmd_t  cmd,
  output rsm_pkg::dp_status_t st,
  input  logic [1:0]          in_command,
  input  logic [9:0]          in_address,
  input  logic signed [31:0]  in_word,
  input  logic signed [31:0]  in_input_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [9:0]          out_next_pc,
  output logic signed [31:0]  out_accumulator,
  output logic                out_print_valid,
  output logic                out_print_is_char,
  output logic signed [31:0]  out_print_value,
  output logic                out_input_taken,
  output logic                out_halted,
  output logic                out_bad_opcode,
  output logic                out_divide_by_zero
);

  import rsm_pkg::*;

  localparam int PCW = $clog2(PROGRAM_WORDS);
  localparam int DAW = $clog2(DATA_WORDS);
  localparam int SPW = $clog2(STACK_DEPTH);

  // Architectural and working registers
  logic [WORD_W-1:0] regs_r [NUM_REGS];
  logic [WORD_W-1:0] regs_nxt [NUM_REGS];
  logic [PCW-1:0]    pc_r, pc_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  op_t               op_r, op_nxt;
  logic [WORD_W-1:0] x_r, x_nxt, y_r, y_nxt, inval_r, inval_nxt;
  logic              pv_r, pv_nxt, pch_r, pch_nxt, tk_r, tk_nxt;
  logic              hlt_r, hlt_nxt, bad_r, bad_nxt, dz_r, dz_nxt;
  logic [WORD_W-1:0] pval_r, pval_nxt;

  // Divider state
  logic [WORD_W-1:0]    dq_r, dq_nxt, rem_r, rem_nxt, mb_r, mb_nxt;
  logic                 qneg_r, qneg_nxt, aneg_r, aneg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W:0]      rem_sh, rem_diff;
  logic                 rem_ge;

  // Output register
  logic              ov_r, ov_nxt;
  logic [PCW-1:0]    opc_r, opc_nxt;
  logic [WORD_W-1:0] oacc_r, oacc_nxt, opval_r, opval_nxt;
  logic              opv_r, opv_nxt, opch_r, opch_nxt, otk_r, otk_nxt;
  logic              ohlt_r, ohlt_nxt, obad_r, obad_nxt, odz_r, odz_nxt;

  // RAM ports
  logic              prog_we, stack_we, data_we;
  logic [WORD_W-1:0] prog_rdata, stack_rdata, data_rdata;
  logic [SPW-1:0]    stack_raddr;

  // ALU operands and helpers
  logic [WORD_W-1:0] ra, rb, r0, ma, mb, product, mov_src;
  logic              prog_bad;
  op_t               prog_op;
  logic [PCW-1:0]    jmp_tgt;

  assign r0      = regs_r[0];
  assign ra      = regs_r[1];
  assign rb      = regs_r[2];
  assign ma      = ra[WORD_W-1] ? (WORD_W'(0) - ra) : ra;
  assign mb      = rb[WORD_W-1] ? (WORD_W'(0) - rb) : rb;
  assign product = ra * rb;
  assign jmp_tgt = ra[PCW-1:0];
  assign mov_src = (y_r < WORD_W'(NUM_REGS)) ? regs_r[y_r[REG_IDX_W-1:0]] : '0;

  // Opcode decode of the word coming out of program RAM
  assign prog_bad = prog_rdata > OP_LAST;
  assign prog_op  = prog_bad ? OP_NOP : op_t'(prog_rdata[4:0]);

  // Divider step: shift one dividend bit into the partial remainder
  assign rem_sh   = {rem_r, dq_r[WORD_W-1]};
  assign rem_diff = rem_sh - {1'b0, mb_r};
  assign rem_ge   = !rem_diff[WORD_W];

  // Status to controller
  always_comb begin
    st.in_is_exec = in_command == CMD_EXEC;
    st.new_args   = op_args(prog_op);
    st.cur_args   = op_args(op_r);
    st.mem_rd     = (op_r == OP_POP) || (op_r == OP_LOAD);
    st.div_run    = ((op_r == OP_DIV) || (op_r == OP_MOD)) && (rb != '0);
    st.div_last   = cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
    st.out_free   = !ov_r || out_ready;
  end

  // RAM write strobes and addresses
  assign prog_we     = cmd.accept && (in_command == CMD_WRITE);
  assign stack_we    = cmd.exec && (op_r == OP_PUSH);
  assign data_we     = cmd.exec && (op_r == OP_STORE);
  assign stack_raddr = sp_r - SPW'(1);

  // Next-state logic
  always_comb begin
    regs_nxt  = regs_r;
    pc_nxt    = pc_r;
    sp_nxt    = sp_r;
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    inval_nxt = inval_r;
    pv_nxt    = pv_r;
    pch_nxt   = pch_r;
    pval_nxt  = pval_r;
    tk_nxt    = tk_r;
    hlt_nxt   = hlt_r;
    bad_nxt   = bad_r;
    dz_nxt    = dz_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    mb_nxt    = mb_r;
    qneg_nxt  = qneg_r;
    aneg_nxt  = aneg_r;
    cnt_nxt   = cnt_r;

    // Take an item: clear flags, set PC or start the opcode fetch
    if (cmd.accept) begin
      inval_nxt = in_input_value;
      pv_nxt    = 1'b0;
      pch_nxt   = 1'b0;
      pval_nxt  = '0;
      tk_nxt    = 1'b0;
      hlt_nxt   = 1'b0;
      bad_nxt   = 1'b0;
      dz_nxt    = 1'b0;
      if (in_command == CMD_SET_PC) begin
        pc_nxt = PCW'(in_address);
      end else if (in_command == CMD_EXEC) begin
        pc_nxt = pc_r + PCW'(1);
      end
    end

    if (cmd.latch_op) begin
      op_nxt  = prog_op;
      bad_nxt = prog_bad;
    end
    if (cmd.fetch) begin
      pc_nxt = pc_r + PCW'(1);
    end
    if (cmd.latch_x) begin
      x_nxt = prog_rdata;
    end
    if (cmd.latch_y) begin
      y_nxt = prog_rdata;
    end

    // Execute the latched opcode
    if (cmd.exec) begin
      case (op_r)
        OP_ADD:   regs_nxt[0] = ra + rb;
        OP_SUB,
        OP_CMP:   regs_nxt[0] = ra - rb;
        OP_MUL:   regs_nxt[0] = product;
        OP_DIV,
        OP_MOD: begin
          if (rb == '0) begin
            regs_nxt[0] = '0;
            dz_nxt      = 1'b1;
          end else begin
            dq_nxt   = ma;
            rem_nxt  = '0;
            mb_nxt   = mb;
            qneg_nxt = ra[WORD_W-1] ^ rb[WORD_W-1];
            aneg_nxt = ra[WORD_W-1];
            cnt_nxt  = '0;
          end
        end
        OP_AND:   regs_nxt[0] = ra & rb;
        OP_OR:    regs_nxt[0] = ra | rb;
        OP_XOR:   regs_nxt[0] = ra ^ rb;
        OP_NOT:   regs_nxt[0] = ~ra;
        OP_SHL:   regs_nxt[0] = ra << rb[4:0];
        OP_SHR:   regs_nxt[0] = WORD_W'($signed(ra) >>> rb[4:0]);
        OP_JMP:   pc_nxt = r0[PCW-1:0];
        OP_JEQ:   if (r0 == '0) pc_nxt = jmp_tgt;
        OP_JNE:   if (r0 != '0) pc_nxt = jmp_tgt;
        OP_JLT:   if (r0[WORD_W-1]) pc_nxt = jmp_tgt;
        OP_JGT:   if (!r0[WORD_W-1] && (r0 != '0)) pc_nxt = jmp_tgt;
        OP_JLE:   if (r0[WORD_W-1] || (r0 == '0)) pc_nxt = jmp_tgt;
        OP_JGE:   if (!r0[WORD_W-1]) pc_nxt = jmp_tgt;
        OP_PUSH:  sp_nxt = sp_r + SPW'(1);
        OP_POP:   sp_nxt = sp_r - SPW'(1);
        OP_MOV: begin
          if (x_r < WORD_W'(NUM_REGS)) regs_nxt[x_r[REG_IDX_W-1:0]] = y_r;
        end
        OP_MOVR: begin
          if (x_r < WORD_W'(NUM_REGS)) regs_nxt[x_r[REG_IDX_W-1:0]] = mov_src;
        end
        OP_PRINT: begin
          pv_nxt   = 1'b1;
          pch_nxt  = x_r != '0;
          pval_nxt = r0;
        end
        OP_READ: begin
          regs_nxt[0] = inval_r;
          tk_nxt      = 1'b1;
        end
        OP_HALT:  hlt_nxt = 1'b1;
        default: ;
      endcase
    end

    // Write back a stack or data word
    if (cmd.mem_wb) begin
      regs_nxt[0] = (op_r == OP_POP) ? stack_rdata : data_rdata;
    end

    // One restoring divide step per cycle
    if (cmd.div_step) begin
      rem_nxt = rem_ge ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      dq_nxt  = {dq_r[WORD_W-2:0], rem_ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
    end

    // Apply signs to quotient or remainder
    if (cmd.div_wb) begin
      if (op_r == OP_DIV) begin
        regs_nxt[0] = qneg_r ? (WORD_W'(0) - dq_r) : dq_r;
      end else begin
        regs_nxt[0] = aneg_r ? (WORD_W'(0) - rem_r) : rem_r;
      end
    end
  end

  // Output register next values
  always_comb begin
    ov_nxt    = ov_r;
    opc_nxt   = opc_r;
    oacc_nxt  = oacc_r;
    opv_nxt   = opv_r;
    opch_nxt  = opch_r;
    opval_nxt = opval_r;
    otk_nxt   = otk_r;
    ohlt_nxt  = ohlt_r;
    obad_nxt  = obad_r;
    odz_nxt   = odz_r;
    if (cmd.publish) begin
      ov_nxt    = 1'b1;
      opc_nxt   = pc_r;
      oacc_nxt  = r0;
      opv_nxt   = pv_r;
      opch_nxt  = pch_r;
      opval_nxt = pval_r;
      otk_nxt   = tk_r;
      ohlt_nxt  = hlt_r;
      obad_nxt  = bad_r;
      odz_nxt   = dz_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{default: '0};
      pc_r   <= '0;
      sp_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      regs_r <= regs_nxt;
      pc_r   <= pc_nxt;
      sp_r   <= sp_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    inval_r <= inval_nxt;
    pv_r    <= pv_nxt;
    pch_r   <= pch_nxt;
    pval_r  <= pval_nxt;
    tk_r    <= tk_nxt;
    hlt_r   <= hlt_nxt;
    bad_r   <= bad_nxt;
    dz_r    <= dz_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    mb_r    <= mb_nxt;
    qneg_r  <= qneg_nxt;
    aneg_r  <= aneg_nxt;
    cnt_r   <= cnt_nxt;
    opc_r   <= opc_nxt;
    oacc_r  <= oacc_nxt;
    opv_r   <= opv_nxt;
    opch_r  <= opch_nxt;
    opval_r <= opval_nxt;
    otk_r   <= otk_nxt;
    ohlt_r  <= ohlt_nxt;
    obad_r  <= obad_nxt;
    odz_r   <= odz_nxt;
  end

  // Program, stack and data stores
  rsm_ram #(.WIDTH(WORD_W), .DEPTH(PROGRAM_WORDS)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PCW'(in_address)),
    .wdata (in_word),
    .raddr (pc_r),
    .rdata (prog_rdata)
  );

  rsm_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (sp_r),
    .wdata (r0),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  rsm_ram #(.WIDTH(WORD_W), .DEPTH(DATA_WORDS)) u_data (
    .clk   (clk),
    .we    (data_we),
    .waddr (ra[DAW-1:0]),
    .wdata (r0),
    .raddr (ra[DAW-1:0]),
    .rdata (data_rdata)
  );

  // Drive result ports
  assign out_valid          = ov_r;
  assign out_next_pc        = PC_OUT_W'(opc_r);
  assign out_accumulator    = oacc_r;
  assign out_print_valid    = opv_r;
  assign out_print_is_char  = opch_r;
  assign out_print_value    = opval_r;
  assign out_input_taken    = otk_r;
  assign out_halted         = ohlt_r;
  assign out_bad_opcode     = obad_r;
  assign out_divide_by_zero = odz_r;

endmodule

FILE: design/register_stack_machine_core.sv
// ----------------------------------------------------------------------------
// register_stack_machine_core
// Small accumulator/stack processor stepped one item at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each item is a command. Execute fetches
// and runs one instruction at the PC, write stores in_word into program RAM
// at in_address, set-PC loads in_address into the PC.
// Result channel (out_valid/out_ready): one result per item with the PC and
// register 0 after the item plus print, read, halt, bad-opcode and
// divide-by-zero flags.
// Execute latches the opcode and operands, runs, then for POP/LOAD reads a store
// and for DIV/MOD with a nonzero divisor runs the serial divider, one quotient
// bit per cycle; write and set-PC skip these. One item is in work at a time; the
// sequencer returns to idle once the result is in the output register.
// A stalled receiver holds the output register; the next item is still
// taken and runs, waiting at its end until the output register frees.
// Reset clears registers, PC, stack pointer and the output valid; the stores
// hold whatever was written. Store depths are powers of two.
// ----------------------------------------------------------------------------
module register_stack_machine_core #(
  parameter int PROGRAM_WORDS = rsm_pkg::PROGRAM_WORDS,
  parameter int DATA_WORDS    = rsm_pkg::DATA_WORDS,
  parameter int STACK_DEPTH   = rsm_pkg::STACK_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [9:0]         in_address,
  input  logic signed [31:0] in_word,
  input  logic signed [31:0] in_input_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_next_pc,
  output logic signed [31:0] out_accumulator,
  output logic               out_print_valid,
  output logic               out_print_is_char,
  output logic signed [31:0] out_print_value,
  output logic               out_input_taken,
  output logic               out_halted,
  output logic               out_bad_opcode,
  output logic               out_divide_by_zero
);

  import rsm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  rsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rsm_datapath #(
    .PROGRAM_WORDS (PROGRAM_WORDS),
    .DATA_WORDS    (DATA_WORDS),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_command         (in_command),
    .in_address         (in_address),
    .in_word            (in_word),
    .in_input_value     (in_input_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_pc        (out_next_pc),
    .out_accumulator    (out_accumulator),
    .out_print_valid    (out_print_valid),
    .out_print_is_char  (out_print_is_char),
    .out_print_value    (out_print_value),
    .out_input_taken    (out_input_taken),
    .out_halted         (out_halted),
    .out_bad_opcode     (out_bad_opcode),
    .out_divide_by_zero (out_divide_by_zero)
  );

`ifndef SYNTHESIS
  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // At most one event flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_print_valid, out_input_taken, out_halted,
                              out_bad_opcode, out_divide_by_zero}) <= 1)
    else $error("conflicting result flags");

  // Print fields are zero without a print
  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_print_valid |-> out_print_value == '0 && !out_print_is_char)
    else $error("print fields set without print");
`endif

endmodule

FILE: test/register_stack_machine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_stack_machine_core_test
// Self-checking bench for the stack machine core: random short programs are
// written, pointed at and stepped, and every result item is checked against
// an in-bench model of registers, PC, stack and stores. Programs are built so
// that no unwritten program, data or stack word is ever read.
// ----------------------------------------------------------------------------
module register_stack_machine_core_test;
  import rsm_pkg::*;

  localparam int NUM_ITEMS = 1150;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  addr;
    logic [31:0] word;
    logic [31:0] in_val;
  } step_item_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic [31:0] acc;
    logic        pr_valid;
    logic        pr_char;
    logic [31:0] pr_value;
    logic        taken;
    logic        halt;
    logic        bad_op;
    logic        div_zero;
  } core_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic [9:0] in_address;
  logic signed [31:0] in_word;
  logic signed [31:0] in_input_value;
  logic out_valid;
  logic out_ready;
  logic [9:0] out_next_pc;
  logic signed [31:0] out_accumulator;
  logic out_print_valid;
  logic out_print_is_char;
  logic signed [31:0] out_print_value;
  logic out_input_taken;
  logic out_halted;
  logic out_bad_opcode;
  logic out_divide_by_zero;

  // Shadow machine state
  logic [31:0] prog_mem [PROGRAM_WORDS];
  logic [31:0] data_mem [DATA_WORDS];
  logic [31:0] stack_mem [STACK_DEPTH];
  bit          prog_set [PROGRAM_WORDS];
  bit          data_set [DATA_WORDS];
  bit          stack_set [STACK_DEPTH];
  logic [31:0] regs [NUM_REGS];
  logic [9:0]  pc;
  logic [7:0]  sp;

  step_item_t   pending_items [$];
  core_result_t expected_results [$];
  int item_count;
  int sent_count;
  int total_items;
  int mismatches;
  logic in_fire;

  register_stack_machine_core i_dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] fetch_word();
    logic [31:0] w;
    w = prog_mem[pc];
    pc = pc + 10'd1;
    return w;
  endfunction

  function automatic logic [31:0] magn(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

  // Advance the shadow machine by one item and return the result it causes
  function automatic core_result_t step_machine(input step_item_t it);
    core_result_t r;
    logic [31:0] opw, a, b, r0, x, y, q;
    op_t op;
    r = '0;
    if (it.cmd == CMD_WRITE) begin
      prog_mem[it.addr] = it.word;
      prog_set[it.addr] = 1'b1;
    end else if (it.cmd == CMD_SET_PC) begin
      pc = it.addr;
    end else if (it.cmd == CMD_EXEC) begin
      opw = fetch_word();
      a = regs[1];
      b = regs[2];
      r0 = regs[0];
      if (opw > OP_LAST) begin
        r.bad_op = 1'b1;
      end else begin
        op = op_t'(opw[4:0]);
        case (op)
          OP_ADD: regs[0] = a + b;
          OP_SUB, OP_CMP: regs[0] = a - b;
          OP_MUL: regs[0] = a * b;
          OP_DIV, OP_MOD: begin
            if (b == 0) begin
              regs[0] = 0;
              r.div_zero = 1'b1;
            end else if (op == OP_DIV) begin
              q = magn(a) / magn(b);
              regs[0] = (a[31] != b[31]) ? 32'd0 - q : q;
            end else begin
              q = magn(a) % magn(b);
              regs[0] = a[31] ? 32'd0 - q : q;
            end
          end
          OP_AND: regs[0] = a & b;
          OP_OR: regs[0] = a | b;
          OP_XOR: regs[0] = a ^ b;
          OP_NOT: regs[0] = ~a;
          OP_SHL: regs[0] = a << b[4:0];
          OP_SHR: regs[0] = $signed(a) >>> b[4:0];
          OP_JMP: pc = r0[9:0];
          OP_JEQ: if (r0 == 0) pc = a[9:0];
          OP_JNE: if (r0 != 0) pc = a[9:0];
          OP_JLT: if (r0[31]) pc = a[9:0];
          OP_JGT: if (!r0[31] && r0 != 0) pc = a[9:0];
          OP_JLE: if (r0[31] || r0 == 0) pc = a[9:0];
          OP_JGE: if (!r0[31]) pc = a[9:0];
          OP_PUSH: begin
            stack_mem[sp] = r0;
            stack_set[sp] = 1'b1;
            sp = sp + 8'd1;
          end
          OP_POP: begin
            sp = sp - 8'd1;
            regs[0] = stack_mem[sp];
          end
          OP_LOAD: regs[0] = data_mem[a[9:0]];
          OP_STORE: begin
            data_mem[a[9:0]] = r0;
            data_set[a[9:0]] = 1'b1;
          end
          OP_MOV: begin
            x = fetch_word();
            y = fetch_word();
            if (x < NUM_REGS) regs[x] = y;
          end
          OP_MOVR: begin
            x = fetch_word();
            y = fetch_word();
            if (x < NUM_REGS) regs[x] = (y < NUM_REGS) ? regs[y] : 32'd0;
          end
          OP_PRINT: begin
            x = fetch_word();
            r.pr_valid = 1'b1;
            r.pr_char = (x != 0);
            r.pr_value = regs[0];
          end
          OP_READ: begin
            regs[0] = it.in_val;
            r.taken = 1'b1;
          end
          OP_HALT: r.halt = 1'b1;
          default: ;
        endcase
      end
    end
    r.next_pc = pc;
    r.acc = regs[0];
    return r;
  endfunction

  // Queue one item and its expected result
  task automatic send_item(input logic [1:0] cmd, input logic [9:0] addr,
                           input logic [31:0] word);
    step_item_t it;
    it.cmd = cmd;
    it.addr = addr;
    it.word = word;
    it.in_val = $urandom;
    pending_items.push_back(it);
    expected_results.push_back(step_machine(it));
    item_count++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 15);
      1: v = 32'd0 - $urandom_range(1, 16);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'd0;
          1: v = 32'd1;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h7FFF_FFFF;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_reg_index();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, NUM_REGS - 1);
  endfunction

  function automatic logic [31:0] pick_opcode();
    if ($urandom_range(0, 19) == 0) return $urandom;
    // favor moves so registers carry varied values
    if ($urandom_range(0, 3) == 0) return OP_MOV;
    return $urandom_range(0, 31);
  endfunction

  // Write one instruction at the PC (forced, or fresh at random, or where
  // nothing is written yet), fill any missing operand words, then execute
  task automatic run_instruction(input bit place, input logic [31:0] opw,
                                 input logic [31:0] x, input logic [31:0] y);
    logic [31:0] op;
    int nargs;
    bit fresh;
    fresh = place || !prog_set[pc] || $urandom_range(0, 99) < 60;
    if (fresh) send_item(CMD_WRITE, pc, place ? opw : pick_opcode());
    op = prog_mem[pc];
    // keep reads of data and stack words to written entries
    if (op == OP_LOAD && !data_set[regs[1][9:0]]) begin
      send_item(CMD_WRITE, pc, OP_STORE);
      op = OP_STORE;
    end
    if (op == OP_POP && !stack_set[sp - 8'd1]) begin
      send_item(CMD_WRITE, pc, OP_PUSH);
      op = OP_PUSH;
    end
    nargs = (op == OP_MOV || op == OP_MOVR) ? 2 : (op == OP_PRINT) ? 1 : 0;
    for (int i = 1; i <= nargs; i++) begin
      if (fresh || !prog_set[pc + 10'(i)]) begin
        if (place)
          send_item(CMD_WRITE, pc + 10'(i), (i == 1) ? x : y);
        else if (op == OP_PRINT)
          send_item(CMD_WRITE, pc + 10'(i), $urandom_range(0, 1) ? 32'd0 : $urandom);
        else if (i == 1 || op == OP_MOVR)
          send_item(CMD_WRITE, pc + 10'(i), pick_reg_index());
        else
          send_item(CMD_WRITE, pc + 10'(i), pick_value());
      end
    end
    send_item(CMD_EXEC, 10'($urandom), $urandom);
  endtask

  task automatic build_stimulus();
    // Directed: overflowing divide, zero divisor, shift wrap, bad opcode,
    // unused command, PC wrap at the top of the store
    send_item(CMD_SET_PC, 10'd1020, $urandom);
    run_instruction(1'b1, OP_MOV, 32'd1, 32'h8000_0000);
    run_instruction(1'b1, OP_MOV, 32'd2, 32'hFFFF_FFFF);
    run_instruction(1'b1, OP_DIV, 0, 0);
    run_instruction(1'b1, OP_MOD, 0, 0);
    run_instruction(1'b1, OP_SHR, 0, 0);
    run_instruction(1'b1, OP_MOV, 32'd2, 32'd0);
    run_instruction(1'b1, OP_MOD, 0, 0);
    run_instruction(1'b1, 32'hFFFF_FFE0, 0, 0);
    send_item(CMD_NONE, 10'h3FF, 32'hFFFF_FFFF);
    // Random: mostly well-formed instruction steps, some noise
    while (item_count < NUM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: send_item(CMD_NONE, 10'($urandom), $urandom);
        1: send_item(CMD_WRITE, 10'($urandom), $urandom);
        2, 3: send_item(CMD_SET_PC, 10'($urandom), $urandom);
        default: run_instruction(1'b0, 0, 0, 0);
      endcase
    end
    total_items = pending_items.size();
  endtask

  function automatic int sender_idle_pct();
    if (sent_count < total_items / 3) return 13;
    if (sent_count < 2 * total_items / 3) return 70;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (sent_count < total_items / 3) return 70;
    if (sent_count < 2 * total_items / 3) return 13;
    return 0;
  endfunction

  // Note acceptance of the held item
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  // Drive items and receiver stalls
  always @(negedge clk) begin
    step_item_t it;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          it = pending_items.pop_front();
          in_command <= it.cmd;
          in_address <= it.addr;
          in_word <= it.word;
          in_input_value <= it.in_val;
          in_valid <= 1'b1;
          sent_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(0, 99) >= receiver_idle_pct();
    end
  end

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    core_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_next_pc, out_accumulator, out_print_valid, out_print_is_char,
             out_print_value, out_input_taken, out_halted, out_bad_opcode,
             out_divide_by_zero};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Reset, run, drain
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = '0;
    in_address = '0;
    in_word = '0;
    in_input_value = '0;
    out_ready = 1'b0;
    in_fire = 1'b0;
    item_count = 0;
    sent_count = 0;
    mismatches = 0;
    regs = '{default: '0};
    pc = '0;
    sp = '0;
    build_stimulus();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
